### hdl/cew_pkg.sv
// ----------------------------------------------------------------------------
// cew_pkg
// Shared widths, record types and constants of the cotangent edge weight block.
// ----------------------------------------------------------------------------
package cew_pkg;

   // default parameter values
   localparam int COORD_W_DEF = 24;
   localparam int FRAC_DEF    = 12;

   // coordinates are brought to this width before any arithmetic
   localparam int WORK_W  = 24;
   localparam int DIFF_W  = WORK_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int DOT_W   = PROD_W + 2;
   localparam int MAG_W   = CROSS_W;

   // guard bits in front of the square root
   localparam int GUARD  = 12;

   // split of a magnitude for squaring with narrow multipliers
   localparam int SQ_LO  = (MAG_W + 1) / 2;
   localparam int SQ_HI  = MAG_W - SQ_LO;
   localparam int SQ_W   = 2 * MAG_W + 2;
   localparam int X_W    = SQ_W + 2 * GUARD;
   localparam int ROOT_W = X_W / 2;

   // weight clamp is cot(1e-6) in whole units, before scaling to fraction lsbs
   localparam int CAP_UNITS   = 1000000;
   localparam int CAP_UNITS_W = $clog2(CAP_UNITS);

   localparam int OUT_W = 32;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one angle of the edge, as classified by the front
   typedef struct packed {
      logic             zero;
      logic [MAG_W-1:0] c0;
      logic [MAG_W-1:0] c1;
      logic [MAG_W-1:0] c2;
      logic [MAG_W-1:0] dmag;
   } cew_side_type;

   typedef struct packed {
      cew_side_type beta;
      cew_side_type alpha;
   } cew_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cew_qstat_type;

endpackage

### hdl/cew_front.sv
// ----------------------------------------------------------------------------
// cew_front
// Takes an edge, forms the side vectors at both apexes, flags zero sides and
// produces cross product and dot product magnitudes for the queue.
// ----------------------------------------------------------------------------
module cew_front #(
   parameter int COORD_WIDTH = cew_pkg::COORD_W_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic signed [COORD_WIDTH-1:0] pt_in [4][3],
   input  cew_pkg::cew_qstat_type        qstat,
   output logic                          push,
   output cew_pkg::cew_item_type         item_out
);
   import cew_pkg::*;

   localparam int REDUCE = (COORD_WIDTH > WORK_W) ? COORD_WIDTH - WORK_W : 0;

   logic                     adv;
   logic                     v0_ff;
   logic                     v1_ff;
   logic signed [WORK_W-1:0] pt_in_red [4][3];
   logic signed [WORK_W-1:0] pt_ff [4][3];
   logic signed [DIFF_W-1:0] u [2][3];
   logic signed [DIFF_W-1:0] v [2][3];
   logic [1:0]               zero_in;
   logic [1:0]               zero_ff;
   logic signed [PROD_W-1:0] prod_in [2][9];
   logic signed [PROD_W-1:0] prod_ff [2][9];
   cew_side_type             side_c [2];

   function automatic logic [MAG_W-1:0] cross_mag(input logic signed [CROSS_W-1:0] x);
      logic signed [CROSS_W-1:0] n;
      n = -x;
      return x[CROSS_W-1] ? MAG_W'(n) : MAG_W'(x);
   endfunction

   function automatic logic [MAG_W-1:0] dot_mag(input logic signed [DOT_W-1:0] x);
      logic signed [DOT_W-1:0] n;
      n = -x;
      return x[DOT_W-1] ? MAG_W'(n) : MAG_W'(x);
   endfunction

   // the front moves as one while the queue has room
   assign adv      = !qstat.full;
   assign in_stall = qstat.full;
   assign push     = v1_ff && adv;

   // bring coordinates to the working width by a floor shift
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         for (int k = 0; k < 3; k++) begin
            pt_in_red[p][k] = WORK_W'(pt_in[p][k] >>> REDUCE);
         end
      end
   end

   // side vectors from the apex (prior for alpha, after for beta) and products
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         for (int k = 0; k < 3; k++) begin
            u[s][k] = DIFF_W'(pt_ff[0][k]) - DIFF_W'(pt_ff[2+s][k]);
            v[s][k] = DIFF_W'(pt_ff[1][k]) - DIFF_W'(pt_ff[2+s][k]);
         end
         zero_in[s] = ((u[s][0] | u[s][1] | u[s][2]) == '0) ||
                      ((v[s][0] | v[s][1] | v[s][2]) == '0);
         prod_in[s][0] = u[s][1] * v[s][2];
         prod_in[s][1] = u[s][2] * v[s][1];
         prod_in[s][2] = u[s][2] * v[s][0];
         prod_in[s][3] = u[s][0] * v[s][2];
         prod_in[s][4] = u[s][0] * v[s][1];
         prod_in[s][5] = u[s][1] * v[s][0];
         prod_in[s][6] = u[s][0] * v[s][0];
         prod_in[s][7] = u[s][1] * v[s][1];
         prod_in[s][8] = u[s][2] * v[s][2];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff   <= pt_in_red;
         prod_ff <= prod_in;
         zero_ff <= zero_in;
      end
   end

   // cross and dot products, reduced to magnitudes
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         side_c[s].zero = zero_ff[s];
         side_c[s].c0   = cross_mag(CROSS_W'(prod_ff[s][0]) - CROSS_W'(prod_ff[s][1]));
         side_c[s].c1   = cross_mag(CROSS_W'(prod_ff[s][2]) - CROSS_W'(prod_ff[s][3]));
         side_c[s].c2   = cross_mag(CROSS_W'(prod_ff[s][4]) - CROSS_W'(prod_ff[s][5]));
         side_c[s].dmag = dot_mag(DOT_W'(prod_ff[s][6]) + DOT_W'(prod_ff[s][7]) +
                                  DOT_W'(prod_ff[s][8]));
      end
   end

   assign item_out.alpha = side_c[0];
   assign item_out.beta  = side_c[1];

endmodule

### hdl/cew_queue.sv
// ----------------------------------------------------------------------------
// cew_queue
// Short first-in first-out queue of classified edges between front and back.
// ----------------------------------------------------------------------------
module cew_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cew_pkg::cew_item_type  push_item,
   input  logic                   pop,
   output cew_pkg::cew_item_type  head,
   output cew_pkg::cew_qstat_type qstat
);
   import cew_pkg::*;

   cew_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff;
   logic [QPTR_W-1:0] rd_ff;
   logic [QPTR_W:0]   cnt_ff;
   logic [QPTR_W:0]   cnt_in;

   // occupancy update
   always_comb begin
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + (QPTR_W+1)'(1);
         2'b01:   cnt_in = cnt_ff - (QPTR_W+1)'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + QPTR_W'(1);
         if (pop)  rd_ff <= rd_ff + QPTR_W'(1);
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   assign head        = slot_ff[rd_ff];
   assign qstat.full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign qstat.empty = (cnt_ff == '0);

endmodule

### hdl/cew_back.sv
// ----------------------------------------------------------------------------
// cew_back
// Squares the cross products, takes the root one bit per stage, divides the
// dot magnitude by it one quotient bit per stage and forms the clamped weight.
// ----------------------------------------------------------------------------
module cew_back #(
   parameter int FRAC_BITS = cew_pkg::FRAC_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cew_pkg::cew_item_type  head,
   input  cew_pkg::cew_qstat_type qstat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [cew_pkg::OUT_W-1:0] rsp_weight,
   output logic                   rsp_degenerate
);
   import cew_pkg::*;

   localparam int QB    = CAP_UNITS_W + FRAC_BITS + 1;
   localparam int NW    = MAG_W + FRAC_BITS + GUARD;
   localparam int SRW   = ROOT_W + 3;
   localparam int DRW   = ROOT_W + 1;
   localparam int DEPTH = ROOT_W + QB + 5;
   localparam int WW    = (QB > OUT_W) ? QB : OUT_W;
   localparam logic [63:0] CAP64 = (64'(CAP_UNITS) << FRAC_BITS) - 64'd1;
   localparam logic [QB-1:0] CAP_Q = CAP64[QB-1:0];
   localparam logic [QB-1:0] LIM_Q = CAP_Q << 1;

   logic             adv;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] deg_ff;
   logic [QB-1:0]    cot_ff [2];
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] weight_ff;
   logic [OUT_W-1:0] weight_in;
   logic             degen_ff;
   logic [QB:0]      sum_in;
   logic [QB-1:0]    half_in;
   logic [QB-1:0]    clamp_in;
   logic [WW-1:0]    wide_in;

   // the back moves as one while the output register can take a result
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], !qstat.empty};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         deg_ff <= {deg_ff[DEPTH-2:0], head.alpha.zero | head.beta.zero};
      end
   end

   // one lane per opposite angle
   for (genvar l = 0; l < 2; l++) begin : g_lane
      cew_side_type               side;
      logic [MAG_W-1:0]           cm [3];
      logic [2*SQ_HI-1:0]         a_hh_ff [3];
      logic [SQ_HI+SQ_LO-1:0]     a_hl_ff [3];
      logic [2*SQ_LO-1:0]         a_ll_ff [3];
      logic [MAG_W-1:0]           a_dm_ff;
      logic [SQ_W-1:0]            b_sq_ff [3];
      logic [MAG_W-1:0]           b_dm_ff;
      logic [SQ_W-1:0]            sq_s_ff    [ROOT_W+1];
      logic [SRW-1:0]             sq_rem_ff  [ROOT_W+1];
      logic [ROOT_W-1:0]          sq_root_ff [ROOT_W+1];
      logic [MAG_W-1:0]           sq_dm_ff   [ROOT_W+1];
      logic [ROOT_W-1:0]          dv_r_ff    [QB+1];
      logic [DRW-1:0]             dv_rem_ff  [QB+1];
      logic [QB-1:0]              dv_q_ff    [QB+1];
      logic [QB-1:0]              dv_n_ff    [QB+1];
      logic                       dv_ovf_ff  [QB+1];
      logic [NW-1:0]              n_full;
      logic [NW-QB-1:0]           n_top;

      if (l == 0) begin : g_alpha
         assign side = head.alpha;
      end else begin : g_beta
         assign side = head.beta;
      end

      assign cm[0] = side.c0;
      assign cm[1] = side.c1;
      assign cm[2] = side.c2;

      // partial products of the squares
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int c = 0; c < 3; c++) begin
               a_hh_ff[c] <= cm[c][SQ_LO +: SQ_HI] * cm[c][SQ_LO +: SQ_HI];
               a_hl_ff[c] <= cm[c][SQ_LO +: SQ_HI] * cm[c][SQ_LO-1:0];
               a_ll_ff[c] <= cm[c][SQ_LO-1:0] * cm[c][SQ_LO-1:0];
            end
            a_dm_ff <= side.dmag;
         end
      end

      // assemble squares
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int c = 0; c < 3; c++) begin
               b_sq_ff[c] <= (SQ_W'(a_hh_ff[c]) << (2*SQ_LO)) +
                             (SQ_W'(a_hl_ff[c]) << (SQ_LO+1)) + SQ_W'(a_ll_ff[c]);
            end
            b_dm_ff <= a_dm_ff;
         end
      end

      // squared length of the cross product, root recurrence starts empty
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_s_ff[0]    <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
            sq_rem_ff[0]  <= '0;
            sq_root_ff[0] <= '0;
            sq_dm_ff[0]   <= b_dm_ff;
         end
      end

      // square root of the guarded sum, one root bit per stage
      for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
         localparam int PL = X_W - 2 - 2*k;
         logic [1:0]     xb;
         logic [SRW-1:0] rsh;
         logic [SRW-1:0] trial;
         logic [SRW-1:0] rnx;
         logic           ge;

         if (PL >= 2*GUARD) begin : g_data
            assign xb = sq_s_ff[k][PL-2*GUARD +: 2];
         end else begin : g_guard
            assign xb = 2'b00;
         end

         assign rsh   = {sq_rem_ff[k][SRW-3:0], xb};
         assign trial = {1'b0, sq_root_ff[k], 2'b01};
         assign ge    = (rsh >= trial);
         assign rnx   = ge ? rsh - trial : rsh;

         always_ff @(posedge clock) begin
            if (adv) begin
               sq_rem_ff[k+1]  <= rnx;
               sq_root_ff[k+1] <= {sq_root_ff[k][ROOT_W-2:0], ge};
               sq_s_ff[k+1]    <= sq_s_ff[k];
               sq_dm_ff[k+1]   <= sq_dm_ff[k];
            end
         end
      end

      // scaled dot magnitude; a quotient past the limit shows in its top part
      assign n_full = {sq_dm_ff[ROOT_W], {(FRAC_BITS+GUARD){1'b0}}};
      assign n_top  = n_full[NW-1:QB];

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ovf_ff[0] <= (DRW'(n_top) >= {1'b0, sq_root_ff[ROOT_W]});
            dv_rem_ff[0] <= DRW'(n_top);
            dv_n_ff[0]   <= n_full[QB-1:0];
            dv_r_ff[0]   <= sq_root_ff[ROOT_W];
            dv_q_ff[0]   <= '0;
         end
      end

      // restoring division, one quotient bit per stage
      for (genvar k = 0; k < QB; k++) begin : g_dv
         logic [DRW-1:0] rsh;
         logic [DRW-1:0] rnx;
         logic           ge;

         assign rsh = {dv_rem_ff[k][DRW-2:0], dv_n_ff[k][QB-1-k]};
         assign ge  = (rsh >= {1'b0, dv_r_ff[k]});
         assign rnx = ge ? rsh - {1'b0, dv_r_ff[k]} : rsh;

         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[k+1] <= rnx;
               dv_q_ff[k+1]   <= {dv_q_ff[k][QB-2:0], ge};
               dv_n_ff[k+1]   <= dv_n_ff[k];
               dv_r_ff[k+1]   <= dv_r_ff[k];
               dv_ovf_ff[k+1] <= dv_ovf_ff[k];
            end
         end
      end

      // cotangent saturated at twice the clamp
      always_ff @(posedge clock) begin
         if (adv) begin
            cot_ff[l] <= (dv_ovf_ff[QB] || (dv_q_ff[QB] > LIM_Q)) ? LIM_Q : dv_q_ff[QB];
         end
      end
   end

   // half sum, clamp, zero for a degenerate edge, fit to the output width
   always_comb begin
      sum_in   = {1'b0, cot_ff[0]} + {1'b0, cot_ff[1]};
      half_in  = sum_in[QB:1];
      clamp_in = (half_in > CAP_Q) ? CAP_Q : half_in;
      wide_in  = WW'(clamp_in);
      if (deg_ff[DEPTH-1]) begin
         weight_in = '0;
      end else if (wide_in > WW'({OUT_W{1'b1}})) begin
         weight_in = '1;
      end else begin
         weight_in = wide_in[OUT_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         weight_ff <= weight_in;
         degen_ff  <= deg_ff[DEPTH-1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_weight     = weight_ff;
   assign rsp_degenerate = degen_ff;

endmodule

### hdl/cotangent_edge_weight.sv
// ----------------------------------------------------------------------------
// cotangent_edge_weight
// Cotangent Laplacian weight of one mesh edge from four 3D points.
//
//   channel   ports                         direction  transfer when
//   req       req_valid/req_stall + 12 pts  in         req_valid & !req_stall
//   rsp       rsp_valid/rsp_stall + weight  out        rsp_valid & !rsp_stall
//
// One edge is taken every cycle while req_stall is low. At FRAC_BITS = 12 an
// edge passes 106 register stages: 2 front stages, the queue, 3 square stages,
// 64 root stages (one root bit each), one divide setup stage, 21 + FRAC_BITS
// divide stages (one quotient bit each), the saturate stage and the output
// register. Reset is synchronous and clears only valids and queue counters.
// rsp_stall with rsp_valid high freezes the back pipeline; the 4-entry queue
// lets the front keep taking edges until it fills, then req_stall rises.
// ----------------------------------------------------------------------------
module cotangent_edge_weight #(
   parameter int COORD_WIDTH = cew_pkg::COORD_W_DEF,
   parameter int FRAC_BITS   = cew_pkg::FRAC_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic signed [COORD_WIDTH-1:0] req_far_x,
   input  logic signed [COORD_WIDTH-1:0] req_far_y,
   input  logic signed [COORD_WIDTH-1:0] req_far_z,
   input  logic signed [COORD_WIDTH-1:0] req_prior_x,
   input  logic signed [COORD_WIDTH-1:0] req_prior_y,
   input  logic signed [COORD_WIDTH-1:0] req_prior_z,
   input  logic signed [COORD_WIDTH-1:0] req_after_x,
   input  logic signed [COORD_WIDTH-1:0] req_after_y,
   input  logic signed [COORD_WIDTH-1:0] req_after_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cew_pkg::OUT_W-1:0]     rsp_weight,
   output logic                          rsp_degenerate
);
   import cew_pkg::*;

   localparam logic [63:0] CAP64 = (64'(CAP_UNITS) << FRAC_BITS) - 64'd1;

   logic signed [COORD_WIDTH-1:0] pt [4][3];
   logic                          q_push;
   logic                          q_pop;
   cew_item_type                  q_in;
   cew_item_type                  q_head;
   cew_qstat_type                 qstat;

   // points in order center, far, prior, after
   assign pt[0][0] = req_center_x;
   assign pt[0][1] = req_center_y;
   assign pt[0][2] = req_center_z;
   assign pt[1][0] = req_far_x;
   assign pt[1][1] = req_far_y;
   assign pt[1][2] = req_far_z;
   assign pt[2][0] = req_prior_x;
   assign pt[2][1] = req_prior_y;
   assign pt[2][2] = req_prior_z;
   assign pt[3][0] = req_after_x;
   assign pt[3][1] = req_after_y;
   assign pt[3][2] = req_after_z;

   cew_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .pt_in    (pt),
      .qstat    (qstat),
      .push     (q_push),
      .item_out (q_in)
   );

   cew_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .qstat     (qstat)
   );

   cew_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .qstat          (qstat),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_weight     (rsp_weight),
      .rsp_degenerate (rsp_degenerate)
   );

   // checks
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_weight == '0))
      else $error("degenerate result with nonzero weight");

   a_weight_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({32'b0, rsp_weight} <= CAP64))
      else $error("weight above clamp");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !qstat.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !qstat.empty)
      else $error("queue read while empty");

endmodule
